>>> rtl/llt_pkg.sv
// ----------------------------------------------------------------------------
// llt_pkg
// Shared types, constants and helpers of the lane line tracker.
// ----------------------------------------------------------------------------
package llt_pkg;

  localparam int LINE_RING_DEPTH    = 5;
  localparam int SEEN_HISTORY_DEPTH = 20;
  localparam int QUEUE_DEPTH        = 2;

  localparam int COORD_W  = 12;
  localparam int DIM_W    = 12;
  localparam int LIMIT_W  = 5;
  localparam int FRAC_W   = 16;
  localparam int SLOPE_W  = 24;
  localparam int OFFSET_W = 32;
  localparam int SSUM_W   = 32;
  localparam int OSUM_W   = 48;
  localparam int CNT_W    = 10;
  localparam int PROD_W   = SLOPE_W + COORD_W + 1;
  localparam int XPOS_W   = 16;
  localparam int DELTA_W  = COORD_W + 1;

  localparam int DIV_W       = 48;
  localparam int DIVR_W      = 32;
  localparam int ITER_W      = $clog2(DIV_W + 1);
  localparam int SLOPE_ITERS = COORD_W + FRAC_W;

  localparam int RING_IDX_W = (LINE_RING_DEPTH > 1) ? $clog2(LINE_RING_DEPTH) : 1;
  localparam int RFILL_W    = $clog2(LINE_RING_DEPTH + 1);
  localparam int HFILL_W    = $clog2(SEEN_HISTORY_DEPTH + 1);
  localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W     = 4 * COORD_W;
  localparam int OUT_FIELDS_W  = 2 + 4 * XPOS_W + DIM_W + 3;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_ADDR_W    = 2;

  localparam logic [CNT_W-1:0] CAND_MAX = '1;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH   = 12'd640;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT  = 12'd480;
  localparam logic [LIMIT_W-1:0] RST_MISSING_LIMIT = 5'd17;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_MISSING_LIMIT = 2'd2
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SLOPE_GO,
    ST_SLOPE_WAIT,
    ST_MUL,
    ST_ACC,
    ST_MS_GO,
    ST_MS_WAIT,
    ST_MO_GO,
    ST_MO_WAIT,
    ST_PUSH,
    ST_RSUM,
    ST_RM_GO,
    ST_RM_WAIT,
    ST_RB_GO,
    ST_RB_WAIT,
    ST_PB_GO,
    ST_PB_WAIT,
    ST_PT_GO,
    ST_PT_WAIT,
    ST_OUT
  } llt_state_e;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [LIMIT_W-1:0] missing_limit;
  } llt_cfg_t;

  typedef struct packed {
    logic                       frame;
    logic                       left;
    logic                       right;
    logic [COORD_W-1:0]         x1;
    logic [COORD_W-1:0]         y1;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
  } llt_op_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
    logic              neg;
    logic [ITER_W-1:0] iters;
  } llt_div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [DIV_W:0] quotient;
  } llt_div_rsp_t;

  function automatic logic [DIM_W-1:0] div3(input logic [DIM_W:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'd43691;
    return p[17 +: DIM_W];
  endfunction

  function automatic logic [DIM_W-1:0] div5(input logic [DIM_W-1:0] x);
    logic [29:0] p;
    p = 30'(x) * 30'd52429;
    return p[18 +: DIM_W];
  endfunction

  function automatic logic signed [XPOS_W-1:0] sat16(input logic signed [DIV_W:0] v);
    logic signed [XPOS_W-1:0] r;
    if (v > (DIV_W+1)'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -(DIV_W+1)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[XPOS_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/lane_line_tracker.sv
// ----------------------------------------------------------------------------
// lane_line_tracker
// Lane line averaging with departure and missing warnings.
// ----------------------------------------------------------------------------
// A segment item in the back part runs one slope division of 28 quotient
// bits, then a multiply and an accumulate; a segment that is not a
// candidate is popped and dropped in the idle state. A frame-end item runs
// up to 12 divisions of 48 quotient bits plus the ring sweeps and yields
// one result. All divisions share the single one-bit-per-cycle divider. A
// two-entry queue lets the input side take items until it is full while
// the back part works or a result waits. No clearing pass follows reset.
module lane_line_tracker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [llt_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // start_x, start_y, end_x, end_y
  input  logic                              s_axis_tuser,  // command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_present, left_bottom_x, left_top_x, right_present, right_bottom_x,
  // right_top_x, top_row, left_departure, right_departure, lane_missing
  output logic [llt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [llt_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [llt_pkg::DIM_W-1:0]         cfg_data_i
);
  import llt_pkg::*;

  llt_cfg_t cfg_q, cfg_d;
  llt_op_t  push_op, pop_op;
  logic     q_push, q_full, q_pop, q_empty;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_FRAME_WIDTH:   cfg_d.width         = cfg_data_i;
        REG_FRAME_HEIGHT:  cfg_d.height        = cfg_data_i;
        REG_MISSING_LIMIT: cfg_d.missing_limit = cfg_data_i[LIMIT_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width         <= RST_FRAME_WIDTH;
      cfg_q.height        <= RST_FRAME_HEIGHT;
      cfg_q.missing_limit <= RST_MISSING_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  llt_front u_front (
    .tvalid_i (s_axis_tvalid),
    .tready_o (s_axis_tready),
    .tdata_i  (s_axis_tdata),
    .tuser_i  (s_axis_tuser),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_op_o   (push_op)
  );

  llt_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .pop_op_o  (pop_op),
    .empty_o   (q_empty)
  );

  llt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_op_i    (pop_op),
    .q_pop_o   (q_pop),
    .tvalid_o  (m_axis_tvalid),
    .tready_i  (m_axis_tready),
    .tdata_o   (m_axis_tdata)
  );

endmodule

>>> rtl/llt_front.sv
// ----------------------------------------------------------------------------
// llt_front
// Accepts segment and frame-end items and classifies segments by side.
// ----------------------------------------------------------------------------
module llt_front (
  input  logic                          tvalid_i,
  output logic                          tready_o,
  input  logic [llt_pkg::IN_DATA_W-1:0] tdata_i,  // start_x, start_y, end_x, end_y
  input  logic                          tuser_i,  // command
  input  llt_pkg::llt_cfg_t             cfg_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output llt_pkg::llt_op_t              q_op_o
);
  import llt_pkg::*;

  logic [COORD_W-1:0]        x1, y1, x2, y2, half;
  logic signed [DELTA_W-1:0] dx, dy;
  logic [DELTA_W-1:0]        adx, ady;
  logic                      cand, neg;

  assign x1   = tdata_i[0*COORD_W +: COORD_W];
  assign y1   = tdata_i[1*COORD_W +: COORD_W];
  assign x2   = tdata_i[2*COORD_W +: COORD_W];
  assign y2   = tdata_i[3*COORD_W +: COORD_W];
  assign half = {1'b0, cfg_i.width[DIM_W-1:1]};

  assign dx  = $signed({1'b0, x2}) - $signed({1'b0, x1});
  assign dy  = $signed({1'b0, y2}) - $signed({1'b0, y1});
  assign adx = dx[DELTA_W-1] ? DELTA_W'(-dx) : DELTA_W'(dx);
  assign ady = dy[DELTA_W-1] ? DELTA_W'(-dy) : DELTA_W'(dy);

  assign cand = ({1'b0, adx} < {ady, 1'b0}) && ({1'b0, ady} < {adx, 1'b0});
  assign neg  = dy[DELTA_W-1] != dx[DELTA_W-1];

  assign tready_o = !q_full_i;
  assign q_push_o = tvalid_i && !q_full_i;

  always_comb begin
    q_op_o       = '0;
    q_op_o.frame = tuser_i;
    q_op_o.left  = !tuser_i && cand && neg && (x1 < half);
    q_op_o.right = !tuser_i && cand && !neg && (x2 > half);
    q_op_o.x1    = x1;
    q_op_o.y1    = y1;
    q_op_o.dx    = dx;
    q_op_o.dy    = dy;
  end

endmodule

>>> rtl/llt_fifo.sv
// ----------------------------------------------------------------------------
// llt_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module llt_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  llt_pkg::llt_op_t push_op_i,
  output logic             full_o,
  input  logic             pop_i,
  output llt_pkg::llt_op_t pop_op_o,
  output logic             empty_o
);
  import llt_pkg::*;

  llt_op_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o   = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o  = cnt_q == '0;
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;
  assign pop_op_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count lost a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> wptr_q == rptr_q)
    else $error("queue pointers apart while empty");

endmodule

>>> rtl/llt_div.sv
// ----------------------------------------------------------------------------
// llt_div
// Shared radix-2 signed divider, truncating toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module llt_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  llt_pkg::llt_div_req_t req_i,
  output llt_pkg::llt_div_rsp_t rsp_o
);
  import llt_pkg::*;

  logic              busy_q, busy_d, done_q, done_d, neg_q;
  logic [ITER_W-1:0] cnt_q, cnt_d, sh;
  logic [DIVR_W-1:0] rem_q, rem_d, den_q;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DIVR_W:0]   part, diff;
  logic              ge;
  logic signed [DIV_W:0] mag;

  assign part = {rem_q, quo_q[DIV_W-1]};
  assign diff = part - {1'b0, den_q};
  assign ge   = part >= {1'b0, den_q};
  assign sh   = ITER_W'(DIV_W) - req_i.iters;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      rem_d  = '0;
      quo_d  = req_i.dividend << sh;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIVR_W-1:0] : part[DIVR_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      den_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end
  end

  assign mag            = $signed({1'b0, quo_q});
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -mag : mag;

endmodule

>>> rtl/llt_back.sv
// ----------------------------------------------------------------------------
// llt_back
// Sequencer that accumulates candidates, updates the line rings and seen
// histories at frame end, projects the lane lines and raises the warnings.
// ----------------------------------------------------------------------------
module llt_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  llt_pkg::llt_cfg_t              cfg_i,
  input  logic                           q_empty_i,
  input  llt_pkg::llt_op_t               q_op_i,
  output logic                           q_pop_o,
  output logic                           tvalid_o,
  input  logic                           tready_i,
  // left_present, left_bottom_x, left_top_x, right_present, right_bottom_x,
  // right_top_x, top_row, left_departure, right_departure, lane_missing
  output logic [llt_pkg::OUT_DATA_W-1:0] tdata_o
);
  import llt_pkg::*;

  llt_state_e state_q, state_d;
  logic       side_q, side_d;
  logic [RING_IDX_W-1:0] idx_q, idx_d;

  logic [COORD_W-1:0]         x1_q, x1_d, y1_q, y1_d;
  logic signed [DELTA_W-1:0]  dx_q, dx_d, dy_q, dy_d;
  logic signed [SLOPE_W-1:0]  s_q, s_d, m_q, m_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [OFFSET_W-1:0] b_q, b_d;
  logic signed [SSUM_W-1:0]   ss_q, ss_d;
  logic signed [OSUM_W-1:0]   so_q, so_d;

  logic signed [SSUM_W-1:0]   ssum_q [2], ssum_d [2];
  logic signed [OSUM_W-1:0]   osum_q [2], osum_d [2];
  logic [CNT_W-1:0]           cnt_q [2], cnt_d [2];
  logic [RFILL_W-1:0]         rfill_q [2], rfill_d [2];
  logic [RING_IDX_W-1:0]      wp_q [2], wp_d [2];
  logic [SEEN_HISTORY_DEPTH-1:0] hist_q [2], hist_d [2];
  logic [HFILL_W-1:0]         hfill_q [2], hfill_d [2], zeros_q [2], zeros_d [2];
  logic signed [SLOPE_W-1:0]  ring_s_q [2][LINE_RING_DEPTH];
  logic signed [OFFSET_W-1:0] ring_o_q [2][LINE_RING_DEPTH];
  logic                       ring_we;

  logic                       present_q [2], present_d [2];
  logic signed [XPOS_W-1:0]   botx_q [2], botx_d [2], topx_q [2], topx_d [2];

  logic                       out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0]      out_data_q, out_data_d;

  llt_div_req_t div_req;
  llt_div_rsp_t div_rsp;

  logic                       seg_take, seen, dropped, last_entry, out_free;
  logic [DIM_W-1:0]           top_row, mid, thr;
  logic signed [SLOPE_W-1:0]  m_abs;
  logic signed [DIV_W-1:0]    num_bot, num_top, sel_num, sel_sum;
  logic                       ldep, rdep, miss;
  logic signed [XPOS_W-1:0]   one_x;

  function automatic logic [DIV_W-1:0] mag48(input logic signed [DIV_W-1:0] v);
    return v[DIV_W-1] ? DIV_W'(-v) : DIV_W'(v);
  endfunction

  function automatic logic near_mid(input logic signed [XPOS_W-1:0] x,
                                    input logic [DIM_W-1:0] md,
                                    input logic [DIM_W-1:0] th);
    logic signed [XPOS_W+1:0] d;
    logic [XPOS_W+1:0]        ad;
    d  = (XPOS_W+2)'(x) - $signed({{(XPOS_W+2-DIM_W){1'b0}}, md});
    ad = d[XPOS_W+1] ? (XPOS_W+2)'(-d) : (XPOS_W+2)'(d);
    return ad < {{(XPOS_W+2-DIM_W){1'b0}}, th};
  endfunction

  llt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign top_row  = div3({cfg_i.height, 1'b0});
  assign mid      = {1'b0, cfg_i.width[DIM_W-1:1]};
  assign thr      = div5(cfg_i.width);
  assign m_abs    = m_q[SLOPE_W-1] ? -m_q : m_q;
  assign num_bot  = $signed(DIV_W'({cfg_i.height, FRAC_W'(0)})) - DIV_W'(b_q);
  assign num_top  = $signed(DIV_W'({top_row, FRAC_W'(0)})) - DIV_W'(b_q);
  assign seg_take = (q_op_i.left && cnt_q[0] != CAND_MAX) ||
                    (q_op_i.right && cnt_q[1] != CAND_MAX);
  assign seen     = cnt_q[side_q] != '0;
  assign dropped  = (hfill_q[side_q] == HFILL_W'(SEEN_HISTORY_DEPTH)) &&
                    !hist_q[side_q][SEEN_HISTORY_DEPTH-1];
  assign last_entry = (RFILL_W'(idx_q) + 1'b1) == rfill_q[side_q];
  assign out_free = !out_valid_q || tready_i;
  assign ring_we  = (state_q == ST_PUSH) && seen;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_op_i.frame) begin
            state_d = ST_MS_GO;
          end else if (seg_take) begin
            state_d = ST_SLOPE_GO;
          end
        end
      end
      ST_SLOPE_GO:   state_d = ST_SLOPE_WAIT;
      ST_SLOPE_WAIT: if (div_rsp.done) state_d = ST_MUL;
      ST_MUL:        state_d = ST_ACC;
      ST_ACC:        state_d = ST_IDLE;
      ST_MS_GO:      state_d = seen ? ST_MS_WAIT : ST_PUSH;
      ST_MS_WAIT:    if (div_rsp.done) state_d = ST_MO_GO;
      ST_MO_GO:      state_d = ST_MO_WAIT;
      ST_MO_WAIT:    if (div_rsp.done) state_d = ST_PUSH;
      ST_PUSH:       state_d = side_q ? ST_RSUM : ST_MS_GO;
      ST_RSUM: begin
        if (rfill_q[side_q] == '0) begin
          state_d = side_q ? ST_OUT : ST_RSUM;
        end else if (last_entry) begin
          state_d = ST_RM_GO;
        end
      end
      ST_RM_GO:      state_d = ST_RM_WAIT;
      ST_RM_WAIT:    if (div_rsp.done) state_d = ST_RB_GO;
      ST_RB_GO:      state_d = ST_RB_WAIT;
      ST_RB_WAIT:    if (div_rsp.done) state_d = ST_PB_GO;
      ST_PB_GO: begin
        if (m_q == '0) begin
          state_d = side_q ? ST_OUT : ST_RSUM;
        end else begin
          state_d = ST_PB_WAIT;
        end
      end
      ST_PB_WAIT:    if (div_rsp.done) state_d = ST_PT_GO;
      ST_PT_GO:      state_d = ST_PT_WAIT;
      ST_PT_WAIT:    if (div_rsp.done) state_d = side_q ? ST_OUT : ST_RSUM;
      ST_OUT:        if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    sel_sum = '0;
    sel_num = '0;
    div_req = '0;
    div_req.iters = ITER_W'(DIV_W);
    unique case (state_q)
      ST_SLOPE_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'({DELTA_W'(dy_q[DELTA_W-1] ? -dy_q : dy_q), FRAC_W'(0)});
        div_req.divisor  = DIVR_W'(DELTA_W'(dx_q[DELTA_W-1] ? -dx_q : dx_q));
        div_req.neg      = dy_q[DELTA_W-1] ^ dx_q[DELTA_W-1];
        div_req.iters    = ITER_W'(SLOPE_ITERS);
      end
      ST_MS_GO, ST_MO_GO: begin
        sel_sum          = (state_q == ST_MS_GO) ? DIV_W'(ssum_q[side_q]) :
                                                  DIV_W'(osum_q[side_q]);
        div_req.start    = seen;
        div_req.dividend = mag48(sel_sum);
        div_req.divisor  = DIVR_W'(cnt_q[side_q]);
        div_req.neg      = sel_sum[DIV_W-1];
      end
      ST_RM_GO, ST_RB_GO: begin
        sel_sum          = (state_q == ST_RM_GO) ? DIV_W'(ss_q) : DIV_W'(so_q);
        div_req.start    = 1'b1;
        div_req.dividend = mag48(sel_sum);
        div_req.divisor  = DIVR_W'(rfill_q[side_q]);
        div_req.neg      = sel_sum[DIV_W-1];
      end
      ST_PB_GO, ST_PT_GO: begin
        sel_num          = (state_q == ST_PB_GO) ? num_bot : num_top;
        div_req.start    = (m_q != '0);
        div_req.dividend = mag48(sel_num);
        div_req.divisor  = DIVR_W'(m_abs);
        div_req.neg      = sel_num[DIV_W-1] ^ m_q[SLOPE_W-1];
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // departure and missing flags
  always_comb begin
    ldep  = 1'b0;
    rdep  = 1'b0;
    one_x = present_q[0] ? botx_q[0] : botx_q[1];
    if (present_q[0] && present_q[1]) begin
      ldep = near_mid(botx_q[0], mid, thr);
      rdep = near_mid(botx_q[1], mid, thr);
    end else if (present_q[0] || present_q[1]) begin
      if (one_x < $signed({{(XPOS_W-DIM_W){1'b0}}, mid})) begin
        ldep = near_mid(one_x, mid, thr);
      end else begin
        rdep = near_mid(one_x, mid, thr);
      end
    end
    miss = (zeros_q[0] > cfg_i.missing_limit) || (zeros_q[1] > cfg_i.missing_limit);
  end

  // datapath updates
  always_comb begin
    side_d      = side_q;
    idx_d       = idx_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    s_d         = s_q;
    m_d         = m_q;
    b_d         = b_q;
    prod_d      = prod_q;
    ss_d        = ss_q;
    so_d        = so_q;
    ssum_d      = ssum_q;
    osum_d      = osum_q;
    cnt_d       = cnt_q;
    rfill_d     = rfill_q;
    wp_d        = wp_q;
    hist_d      = hist_q;
    hfill_d     = hfill_q;
    zeros_d     = zeros_q;
    present_d   = present_q;
    botx_d      = botx_q;
    topx_d      = topx_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    q_pop_o     = 1'b0;
    if (tready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          side_d  = q_op_i.frame ? 1'b0 : !q_op_i.left;
          x1_d    = q_op_i.x1;
          y1_d    = q_op_i.y1;
          dx_d    = q_op_i.dx;
          dy_d    = q_op_i.dy;
        end
      end
      ST_SLOPE_WAIT: begin
        if (div_rsp.done) begin
          s_d = div_rsp.quotient[SLOPE_W-1:0];
        end
      end
      ST_MUL: begin
        prod_d = PROD_W'(s_q) * $signed({1'b0, x1_q});
      end
      ST_ACC: begin
        ssum_d[side_q] = ssum_q[side_q] + SSUM_W'(s_q);
        osum_d[side_q] = osum_q[side_q] + $signed(OSUM_W'({y1_q, FRAC_W'(0)}))
                         - OSUM_W'(prod_q);
        cnt_d[side_q]  = cnt_q[side_q] + 1'b1;
      end
      ST_MS_WAIT: begin
        if (div_rsp.done) begin
          m_d = div_rsp.quotient[SLOPE_W-1:0];
        end
      end
      ST_MO_WAIT: begin
        if (div_rsp.done) begin
          b_d = div_rsp.quotient[OFFSET_W-1:0];
        end
      end
      ST_PUSH: begin
        if (seen) begin
          wp_d[side_q] = (wp_q[side_q] == RING_IDX_W'(LINE_RING_DEPTH - 1)) ? '0 :
                         wp_q[side_q] + 1'b1;
          if (rfill_q[side_q] != RFILL_W'(LINE_RING_DEPTH)) begin
            rfill_d[side_q] = rfill_q[side_q] + 1'b1;
          end
        end
        hist_d[side_q]  = (hist_q[side_q] << 1) | SEEN_HISTORY_DEPTH'(seen);
        if (hfill_q[side_q] != HFILL_W'(SEEN_HISTORY_DEPTH)) begin
          hfill_d[side_q] = hfill_q[side_q] + 1'b1;
        end
        zeros_d[side_q] = zeros_q[side_q] + HFILL_W'(!seen) - HFILL_W'(dropped);
        ssum_d[side_q]  = '0;
        osum_d[side_q]  = '0;
        cnt_d[side_q]   = '0;
        side_d = !side_q;
        idx_d  = '0;
        ss_d   = '0;
        so_d   = '0;
      end
      ST_RSUM: begin
        if (rfill_q[side_q] == '0) begin
          present_d[side_q] = 1'b0;
          botx_d[side_q]    = '0;
          topx_d[side_q]    = '0;
          side_d = 1'b1;
          idx_d  = '0;
        end else begin
          ss_d  = ss_q + SSUM_W'(ring_s_q[side_q][idx_q]);
          so_d  = so_q + OSUM_W'(ring_o_q[side_q][idx_q]);
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RM_WAIT: begin
        if (div_rsp.done) begin
          m_d = div_rsp.quotient[SLOPE_W-1:0];
        end
      end
      ST_RB_WAIT: begin
        if (div_rsp.done) begin
          b_d = div_rsp.quotient[OFFSET_W-1:0];
        end
      end
      ST_PB_GO: begin
        if (m_q == '0) begin
          present_d[side_q] = 1'b1;
          botx_d[side_q]    = '0;
          topx_d[side_q]    = '0;
          side_d = 1'b1;
          idx_d  = '0;
          ss_d   = '0;
          so_d   = '0;
        end
      end
      ST_PB_WAIT: begin
        if (div_rsp.done) begin
          botx_d[side_q] = sat16(div_rsp.quotient);
        end
      end
      ST_PT_WAIT: begin
        if (div_rsp.done) begin
          topx_d[side_q]    = sat16(div_rsp.quotient);
          present_d[side_q] = 1'b1;
          side_d = 1'b1;
          idx_d  = '0;
          ss_d   = '0;
          so_d   = '0;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), miss, rdep, ldep, top_row,
                         topx_q[1], botx_q[1], present_q[1],
                         topx_q[0], botx_q[0], present_q[0]};
        end
      end
      default: begin
        out_valid_d = out_valid_d;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        ssum_q[s]    <= '0;
        osum_q[s]    <= '0;
        cnt_q[s]     <= '0;
        rfill_q[s]   <= '0;
        wp_q[s]      <= '0;
        hist_q[s]    <= '0;
        hfill_q[s]   <= '0;
        zeros_q[s]   <= '0;
        present_q[s] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      ssum_q      <= ssum_d;
      osum_q      <= osum_d;
      cnt_q       <= cnt_d;
      rfill_q     <= rfill_d;
      wp_q        <= wp_d;
      hist_q      <= hist_d;
      hfill_q     <= hfill_d;
      zeros_q     <= zeros_d;
      present_q   <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q       <= x1_d;
    y1_q       <= y1_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    s_q        <= s_d;
    m_q        <= m_d;
    b_q        <= b_d;
    prod_q     <= prod_d;
    ss_q       <= ss_d;
    so_q       <= so_d;
    botx_q     <= botx_d;
    topx_q     <= topx_d;
    out_data_q <= out_data_d;
    if (ring_we) begin
      ring_s_q[side_q][wp_q[side_q]] <= m_q;
      ring_o_q[side_q][wp_q[side_q]] <= b_q;
    end
  end

  assign tvalid_o = out_valid_q;
  assign tdata_o  = out_data_q;

  a_ring_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rfill_q[0] <= RFILL_W'(LINE_RING_DEPTH) && rfill_q[1] <= RFILL_W'(LINE_RING_DEPTH))
    else $error("line ring fill above depth");

  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zeros_q[0] <= hfill_q[0] && zeros_q[1] <= hfill_q[1])
    else $error("miss count above history fill");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output step");

endmodule
